[sv/cstk_pkg.sv]
`timescale 1ns / 1ps
package cstk_pkg;

   localparam int OFFSET_BITS_DEF      = 32;
   localparam int LENGTH_BITS_DEF      = 16;
   localparam int LINE_COLUMN_BITS_DEF = 16;

   localparam int KIND_W     = 4;
   localparam int DETAIL_W   = 5;
   localparam int KW_DEPTH   = 6;
   localparam int OUTQ_DEPTH = 4;

   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [DETAIL_W-1:0] detail_type;

   localparam kind_type KIND_END     = 4'd0;
   localparam kind_type KIND_IDENT   = 4'd1;
   localparam kind_type KIND_KEYWORD = 4'd2;
   localparam kind_type KIND_NUMBER  = 4'd3;
   localparam kind_type KIND_STRING  = 4'd4;
   localparam kind_type KIND_OPER    = 4'd5;
   localparam kind_type KIND_COLON   = 4'd6;
   localparam kind_type KIND_LPAREN  = 4'd7;
   localparam kind_type KIND_RPAREN  = 4'd8;
   localparam kind_type KIND_LBRACE  = 4'd9;
   localparam kind_type KIND_RBRACE  = 4'd10;
   localparam kind_type KIND_SEMI    = 4'd11;
   localparam kind_type KIND_COMMA   = 4'd12;
   localparam kind_type KIND_ERROR   = 4'd13;

   localparam detail_type DETAIL_NONE = 5'd0;
   localparam detail_type KW_VOID     = 5'd1;
   localparam detail_type KW_INT      = 5'd2;
   localparam detail_type KW_CHAR     = 5'd3;
   localparam detail_type KW_RETURN   = 5'd4;

   localparam detail_type OP_PLUS   = 5'd1;
   localparam detail_type OP_SUB    = 5'd2;
   localparam detail_type OP_STAR   = 5'd3;
   localparam detail_type OP_SLASH  = 5'd4;
   localparam detail_type OP_PCT    = 5'd5;
   localparam detail_type OP_SET    = 5'd6;
   localparam detail_type OP_NOT    = 5'd7;
   localparam detail_type OP_LT     = 5'd8;
   localparam detail_type OP_GT     = 5'd9;
   localparam detail_type OP_AND    = 5'd10;
   localparam detail_type OP_OR     = 5'd11;
   localparam detail_type OP_DOT    = 5'd12;
   localparam detail_type OP_INC    = 5'd13;
   localparam detail_type OP_DEC    = 5'd14;
   localparam detail_type OP_ADDEQ  = 5'd15;
   localparam detail_type OP_SUBEQ  = 5'd16;
   localparam detail_type OP_MULEQ  = 5'd17;
   localparam detail_type OP_DIVEQ  = 5'd18;
   localparam detail_type OP_MODEQ  = 5'd19;
   localparam detail_type OP_EQ     = 5'd20;
   localparam detail_type OP_NE     = 5'd21;
   localparam detail_type OP_LE     = 5'd22;
   localparam detail_type OP_GE     = 5'd23;
   localparam detail_type OP_SHL    = 5'd24;
   localparam detail_type OP_SHR    = 5'd25;
   localparam detail_type OP_LAND   = 5'd26;
   localparam detail_type OP_LOR    = 5'd27;

   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   function automatic logic is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic detail_type single_op(logic [7:0] p);
      detail_type d;
      case (p)
         "+":     d = OP_PLUS;
         "-":     d = OP_SUB;
         "*":     d = OP_STAR;
         "/":     d = OP_SLASH;
         "%":     d = OP_PCT;
         "=":     d = OP_SET;
         "!":     d = OP_NOT;
         "<":     d = OP_LT;
         ">":     d = OP_GT;
         "&":     d = OP_AND;
         "|":     d = OP_OR;
         default: d = OP_DOT;
      endcase
      return d;
   endfunction

   function automatic logic is_op_start(logic [7:0] c);
      return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" || c == "=" ||
             c == "!" || c == "<" || c == ">" || c == "&" || c == "|";
   endfunction

   function automatic detail_type pair_op(logic [7:0] p, logic [7:0] n);
      detail_type d;
      d = DETAIL_NONE;
      if (n == "=") begin
         case (p)
            "+":     d = OP_ADDEQ;
            "-":     d = OP_SUBEQ;
            "*":     d = OP_MULEQ;
            "/":     d = OP_DIVEQ;
            "%":     d = OP_MODEQ;
            "=":     d = OP_EQ;
            "!":     d = OP_NE;
            "<":     d = OP_LE;
            ">":     d = OP_GE;
            default: d = DETAIL_NONE;
         endcase
      end else if (n == p) begin
         case (p)
            "+":     d = OP_INC;
            "-":     d = OP_DEC;
            "<":     d = OP_SHL;
            ">":     d = OP_SHR;
            "&":     d = OP_LAND;
            "|":     d = OP_LOR;
            default: d = DETAIL_NONE;
         endcase
      end
      return d;
   endfunction

   function automatic kind_type punct_kind(logic [7:0] c);
      kind_type k;
      case (c)
         ".":     k = KIND_OPER;
         ":":     k = KIND_COLON;
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         "{":     k = KIND_LBRACE;
         "}":     k = KIND_RBRACE;
         ";":     k = KIND_SEMI;
         ",":     k = KIND_COMMA;
         default: k = KIND_ERROR;
      endcase
      return k;
   endfunction

endpackage

[sv/cstk_scan.sv]
`timescale 1ns / 1ps
module cstk_scan #(
   parameter int OFFSET_BITS      = 32,
   parameter int LENGTH_BITS      = 16,
   parameter int LINE_COLUMN_BITS = 16,
   parameter int WORD_W           = 90
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                room,
   output cstk_pkg::push_type  push,
   output logic [WORD_W-1:0]   word_a,
   output logic [WORD_W-1:0]   word_b
);
   import cstk_pkg::*;

   localparam int OB       = OFFSET_BITS;
   localparam int LB       = LENGTH_BITS;
   localparam int CB       = LINE_COLUMN_BITS;
   localparam int TDATA_W  = WORD_W - KIND_W - 1;
   localparam int KW_IDX_W = $clog2(KW_DEPTH);

   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_IDENT  = 3'd1;
   localparam logic [2:0] MODE_NUMBER = 3'd2;
   localparam logic [2:0] MODE_STRING = 3'd3;
   localparam logic [2:0] MODE_OPER   = 3'd4;

   logic [7:0]                 byte_ff;
   logic                       vld_ff;
   logic                       take;

   logic [2:0]                 mode_ff, mode_in;
   logic [7:0]                 pend_ff, pend_in;
   logic [KW_DEPTH-1:0][7:0]   kw_ff, kw_in;
   logic [OB-1:0]              tsoff_ff, tsoff_in, off_ff, off_in;
   logic [CB-1:0]              tsline_ff, tsline_in, tscol_ff, tscol_in;
   logic [CB-1:0]              line_ff, line_in, col_ff, col_in;
   logic [LB-1:0]              run_ff, run_in;

   logic [7:0]                 c;
   logic                       c_letter, c_digit, c_word, c_ws, c_quote;
   logic [OB-1:0]              off_inc;
   logic [CB-1:0]              line_adv, col_adv;
   logic [LB-1:0]              run_inc;
   detail_type                 kw_code, pair_code;
   logic                       do_idle, do_adv;
   logic                       a_vld, b_vld;
   kind_type                   a_kind, b_kind;
   detail_type                 a_detail, b_detail;
   logic [LB-1:0]              a_len, b_len;
   logic [WORD_W-1:0]          pack_a, pack_b;

   assign take       = vld_ff && room;
   assign req_tready = !vld_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         vld_ff <= 1'b1;
      end else if (take) begin
         vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         byte_ff <= req_tdata;
      end
   end

   assign c        = byte_ff;
   assign c_letter = is_letter(c);
   assign c_digit  = is_digit(c);
   assign c_word   = c_letter || c_digit || c == "_";
   assign c_ws     = c == " " || c == 8'h09 || c == 8'h0a;
   assign c_quote  = c == 8'h22 || c == 8'h27;
   assign off_inc  = off_ff + OB'(1);
   assign line_adv = (&line_ff) ? line_ff : line_ff + CB'(1);
   assign col_adv  = (&col_ff) ? col_ff : col_ff + CB'(1);
   assign run_inc  = (&run_ff) ? run_ff : run_ff + LB'(1);
   assign pair_code = pair_op(pend_ff, c);

   always_comb begin
      kw_code = DETAIL_NONE;
      if (run_ff == LB'(4) && kw_ff[0] == "v" && kw_ff[1] == "o" && kw_ff[2] == "i" &&
          kw_ff[3] == "d") begin
         kw_code = KW_VOID;
      end else if (run_ff == LB'(3) && kw_ff[0] == "i" && kw_ff[1] == "n" &&
                   kw_ff[2] == "t") begin
         kw_code = KW_INT;
      end else if (run_ff == LB'(4) && kw_ff[0] == "c" && kw_ff[1] == "h" &&
                   kw_ff[2] == "a" && kw_ff[3] == "r") begin
         kw_code = KW_CHAR;
      end else if (run_ff == LB'(6) && kw_ff[0] == "r" && kw_ff[1] == "e" &&
                   kw_ff[2] == "t" && kw_ff[3] == "u" && kw_ff[4] == "r" &&
                   kw_ff[5] == "n") begin
         kw_code = KW_RETURN;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      pend_in   = pend_ff;
      kw_in     = kw_ff;
      tsoff_in  = tsoff_ff;
      tsline_in = tsline_ff;
      tscol_in  = tscol_ff;
      off_in    = off_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      run_in    = run_ff;
      do_idle   = 1'b0;
      do_adv    = 1'b0;
      a_vld     = 1'b0;
      a_kind    = KIND_END;
      a_detail  = DETAIL_NONE;
      a_len     = run_ff;
      b_vld     = 1'b0;
      b_kind    = KIND_END;
      b_detail  = DETAIL_NONE;
      b_len     = '0;

      unique case (mode_ff)
         MODE_IDENT: begin
            if (c_word) begin
               if (run_ff < LB'(KW_DEPTH)) begin
                  kw_in[run_ff[KW_IDX_W-1:0]] = c;
               end
               run_in = run_inc;
               do_adv = 1'b1;
            end else begin
               a_vld    = 1'b1;
               a_kind   = (kw_code != DETAIL_NONE) ? KIND_KEYWORD : KIND_IDENT;
               a_detail = kw_code;
               mode_in  = MODE_IDLE;
               do_idle  = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (c_digit) begin
               run_in = run_inc;
               do_adv = 1'b1;
            end else begin
               a_vld   = 1'b1;
               a_kind  = c_letter ? KIND_ERROR : KIND_NUMBER;
               mode_in = MODE_IDLE;
               do_idle = 1'b1;
            end
         end
         MODE_STRING: begin
            if (c == 8'h22) begin
               a_vld   = 1'b1;
               a_kind  = KIND_STRING;
               mode_in = MODE_IDLE;
               do_adv  = 1'b1;
            end else if (c != 8'h00) begin
               run_in = run_inc;
               do_adv = 1'b1;
            end else begin
               a_vld   = 1'b1;
               a_kind  = KIND_STRING;
               mode_in = MODE_IDLE;
               do_idle = 1'b1;
            end
         end
         MODE_OPER: begin
            mode_in = MODE_IDLE;
            a_vld   = 1'b1;
            a_kind  = KIND_OPER;
            if (pair_code != DETAIL_NONE) begin
               a_detail = pair_code;
               a_len    = LB'(2);
               do_adv   = 1'b1;
            end else begin
               a_detail = single_op(pend_ff);
               a_len    = LB'(1);
               do_idle  = 1'b1;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
            do_idle = 1'b1;
         end
      endcase

      if (do_idle) begin
         if (c == 8'h00) begin
            b_vld     = 1'b1;
            b_kind    = KIND_END;
            mode_in   = MODE_IDLE;
            pend_in   = '0;
            kw_in     = '0;
            tsoff_in  = '0;
            tsline_in = CB'(1);
            tscol_in  = CB'(1);
            off_in    = '0;
            line_in   = CB'(1);
            col_in    = CB'(1);
            run_in    = '0;
         end else begin
            do_adv = 1'b1;
            if (c_ws) begin
               // whitespace only moves the position
            end else if (c_letter || c == "_") begin
               tsoff_in  = off_ff;
               tsline_in = line_ff;
               tscol_in  = col_ff;
               kw_in     = '0;
               kw_in[0]  = c;
               run_in    = LB'(1);
               mode_in   = MODE_IDENT;
            end else if (c_digit) begin
               tsoff_in  = off_ff;
               tsline_in = line_ff;
               tscol_in  = col_ff;
               run_in    = LB'(1);
               mode_in   = MODE_NUMBER;
            end else if (c_quote) begin
               tsoff_in  = off_inc;
               tsline_in = line_ff;
               tscol_in  = col_ff;
               run_in    = '0;
               mode_in   = MODE_STRING;
            end else if (is_op_start(c)) begin
               tsoff_in  = off_ff;
               tsline_in = line_ff;
               tscol_in  = col_ff;
               pend_in   = c;
               mode_in   = MODE_OPER;
            end else begin
               b_vld    = 1'b1;
               b_kind   = punct_kind(c);
               b_detail = (b_kind == KIND_OPER) ? OP_DOT : DETAIL_NONE;
               b_len    = LB'(1);
            end
         end
      end

      if (do_adv) begin
         off_in = off_inc;
         if (c == 8'h0a) begin
            line_in = line_adv;
            col_in  = CB'(1);
         end else begin
            col_in = col_adv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pend_ff   <= '0;
         kw_ff     <= '0;
         tsoff_ff  <= '0;
         tsline_ff <= CB'(1);
         tscol_ff  <= CB'(1);
         off_ff    <= '0;
         line_ff   <= CB'(1);
         col_ff    <= CB'(1);
         run_ff    <= '0;
      end else if (take) begin
         mode_ff   <= mode_in;
         pend_ff   <= pend_in;
         kw_ff     <= kw_in;
         tsoff_ff  <= tsoff_in;
         tsline_ff <= tsline_in;
         tscol_ff  <= tscol_in;
         off_ff    <= off_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         run_ff    <= run_in;
      end
   end

   // word layout: {last, kind, tdata}; tdata = {pad, col, line, len, offset, detail}
   assign pack_a = {!b_vld, a_kind,
                    TDATA_W'({tscol_ff, tsline_ff, a_len, tsoff_ff, a_detail})};
   assign pack_b = {1'b1, b_kind,
                    TDATA_W'({col_ff, line_ff, b_len, off_ff, b_detail})};

   assign push.first  = take && (a_vld || b_vld);
   assign push.second = take && a_vld && b_vld;
   assign word_a      = a_vld ? pack_a : pack_b;
   assign word_b      = pack_b;

endmodule

[sv/cstk_outq.sv]
`timescale 1ns / 1ps
module cstk_outq #(
   parameter int WIDTH = 90
) (
   input  logic                clock,
   input  logic                reset,
   input  cstk_pkg::push_type  push,
   input  logic [WIDTH-1:0]    din_a,
   input  logic [WIDTH-1:0]    din_b,
   output logic                room,
   output logic                dout_valid,
   input  logic                dout_ready,
   output logic [WIDTH-1:0]    dout
);
   import cstk_pkg::*;

   localparam int PTR_W = $clog2(OUTQ_DEPTH);
   localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [OUTQ_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in, wr_next;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign pop        = dout_valid && dout_ready;
   assign dout_valid = count_ff != '0;
   assign dout       = mem_ff[rd_ff];
   assign room       = count_ff <= CNT_W'(OUTQ_DEPTH - 2);
   assign wr_next    = wr_ff + PTR_W'(1);
   assign wr_in      = wr_ff + PTR_W'(push.first) + PTR_W'(push.second);
   assign rd_in      = rd_ff + PTR_W'(pop);
   assign count_in   = count_ff + CNT_W'(push.first) + CNT_W'(push.second) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         mem_ff[wr_ff] <= din_a;
      end
      if (push.second) begin
         mem_ff[wr_next] <= din_b;
      end
   end

endmodule

[sv/c_subset_token_scanner_core.sv]
`timescale 1ns / 1ps
// Token scanner for a small C subset.
// req_*: one source byte per word; byte zero ends the source, emits the end
//   token and returns the scanner to its reset state for the next source.
// rsp_*: one token per word. tuser is the token kind, tdata carries detail,
//   start offset, length, line and column, tlast marks the final token that
//   one source byte produced (a byte yields zero, one or two tokens).
// Path: a byte's handshake loads the input register; the scan logic then
//   writes its tokens into the output queue, from which the receiver takes them.
// Throughput: one byte per cycle while the queue has room and each byte
//   makes at most one token; a byte's two tokens enter together but leave
//   one by one through the single read port of the four-word output queue.
// Stall: req_tready stays high while the output queue has room for two
//   words; a stalled receiver fills the queue and then holds off the sender,
//   and no token is dropped or repeated.
// Reset: synchronous, active high; clears scanner position (line 1,
//   column 1, offset 0), mode and the output queue.
module c_subset_token_scanner_core #(
   parameter int OFFSET_BITS      = cstk_pkg::OFFSET_BITS_DEF,
   parameter int LENGTH_BITS      = cstk_pkg::LENGTH_BITS_DEF,
   parameter int LINE_COLUMN_BITS = cstk_pkg::LINE_COLUMN_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // char_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // token_detail, start_offset, lexeme_length, start_line, start_column, zero pad
   output logic [((cstk_pkg::DETAIL_W + OFFSET_BITS + LENGTH_BITS
                   + 2 * LINE_COLUMN_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic [cstk_pkg::KIND_W-1:0]     rsp_tuser,  // token_kind
   output logic                            rsp_tlast   // last_of_run
);
   import cstk_pkg::*;

   localparam int TDATA_W = ((DETAIL_W + OFFSET_BITS + LENGTH_BITS
                              + 2 * LINE_COLUMN_BITS + 7) / 8) * 8;
   localparam int WORD_W  = TDATA_W + KIND_W + 1;

   push_type          push;
   logic              room;
   logic [WORD_W-1:0] word_a, word_b, word_out;

   cstk_scan #(
      .OFFSET_BITS      (OFFSET_BITS),
      .LENGTH_BITS      (LENGTH_BITS),
      .LINE_COLUMN_BITS (LINE_COLUMN_BITS),
      .WORD_W           (WORD_W)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .room       (room),
      .push       (push),
      .word_a     (word_a),
      .word_b     (word_b)
   );

   cstk_outq #(
      .WIDTH (WORD_W)
   ) u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .din_a      (word_a),
      .din_b      (word_b),
      .room       (room),
      .dout_valid (rsp_tvalid),
      .dout_ready (rsp_tready),
      .dout       (word_out)
   );

   assign rsp_tdata = word_out[TDATA_W-1:0];
   assign rsp_tuser = word_out[TDATA_W +: KIND_W];
   assign rsp_tlast = word_out[WORD_W-1];

endmodule

[sv/cstk_checker.sv]
`timescale 1ns / 1ps
module cstk_checker #(
   parameter int OFFSET_BITS      = cstk_pkg::OFFSET_BITS_DEF,
   parameter int LENGTH_BITS      = cstk_pkg::LENGTH_BITS_DEF,
   parameter int LINE_COLUMN_BITS = cstk_pkg::LINE_COLUMN_BITS_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [7:0]                      req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [((cstk_pkg::DETAIL_W + OFFSET_BITS + LENGTH_BITS
                  + 2 * LINE_COLUMN_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   input logic [cstk_pkg::KIND_W-1:0]     rsp_tuser,
   input logic                            rsp_tlast
);
   import cstk_pkg::*;

   localparam int LEN_LO  = DETAIL_W + OFFSET_BITS;
   localparam int LINE_LO = LEN_LO + LENGTH_BITS;
   localparam int COL_LO  = LINE_LO + LINE_COLUMN_BITS;

   logic [DETAIL_W-1:0]         detail;
   logic [LENGTH_BITS-1:0]      len;
   logic [LINE_COLUMN_BITS-1:0] line, col;
   logic                        req_word;

   assign detail   = rsp_tdata[DETAIL_W-1:0];
   assign len      = rsp_tdata[LEN_LO +: LENGTH_BITS];
   assign line     = rsp_tdata[LINE_LO +: LINE_COLUMN_BITS];
   assign col      = rsp_tdata[COL_LO +: LINE_COLUMN_BITS];
   assign req_word = req_tvalid && req_tready && req_tdata == 8'h00;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
         $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("token word changed while stalled");

   a_end_token: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_END |-> len == '0 && detail == DETAIL_NONE &&
         rsp_tlast)
      else $error("malformed end token");

   a_keyword: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_KEYWORD |-> detail != DETAIL_NONE &&
         detail <= KW_RETURN)
      else $error("keyword token without keyword code");

   a_position: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> line != '0 && col != '0)
      else $error("token at line or column zero");

   a_first_end: assert property (@(posedge clock) disable iff (reset)
      req_word && !rsp_tvalid |=> ##1 rsp_tvalid)
      else $error("end of source produced no token");

endmodule

bind c_subset_token_scanner_core cstk_checker #(
   .OFFSET_BITS      (OFFSET_BITS),
   .LENGTH_BITS      (LENGTH_BITS),
   .LINE_COLUMN_BITS (LINE_COLUMN_BITS)
) u_cstk_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[dv/c_subset_token_scanner_core_test.sv]
`timescale 1ns / 1ps
module c_subset_token_scanner_core_test;
   import cstk_pkg::*;

   localparam int OB       = OFFSET_BITS_DEF;
   localparam int LB       = LENGTH_BITS_DEF;
   localparam int LCB      = LINE_COLUMN_BITS_DEF;
   localparam int DATA_W   = ((DETAIL_W + OB + LB + 2 * LCB + 7) / 8) * 8;
   localparam int OFF_LSB  = DETAIL_W;
   localparam int LEN_LSB  = OFF_LSB + OB;
   localparam int LINE_LSB = LEN_LSB + LB;
   localparam int COL_LSB  = LINE_LSB + LCB;
   localparam int RANDOM_BYTES = 960;
   localparam int LONG_RUN = 24;
   localparam int MAX_GAP  = 11;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_STRING, SCAN_OPER
   } scan_mode_type;

   typedef struct {
      kind_type         kind;
      detail_type       detail;
      logic [OB-1:0]    offset;
      logic [LB-1:0]    length;
      logic [LCB-1:0]   line;
      logic [LCB-1:0]   column;
      logic             last;
   } token_type;

   typedef struct {
      logic [7:0] c;
      bit         typed;
      token_type  tok;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [7:0]        req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0] rsp_tuser;
   logic              rsp_tlast;

   c_subset_token_scanner_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   detail_type op_pairs[string] = '{
      "++": OP_INC, "--": OP_DEC, "+=": OP_ADDEQ, "-=": OP_SUBEQ, "*=": OP_MULEQ,
      "/=": OP_DIVEQ, "%=": OP_MODEQ, "==": OP_EQ, "!=": OP_NE, "<=": OP_LE,
      ">=": OP_GE, "<<": OP_SHL, ">>": OP_SHR, "&&": OP_LAND, "||": OP_LOR
   };
   detail_type op_singles[string] = '{
      "+": OP_PLUS, "-": OP_SUB, "*": OP_STAR, "/": OP_SLASH, "%": OP_PCT,
      "=": OP_SET, "!": OP_NOT, "<": OP_LT, ">": OP_GT, "&": OP_AND, "|": OP_OR
   };
   kind_type punct_kinds[string] = '{
      ".": KIND_OPER, ":": KIND_COLON, "(": KIND_LPAREN, ")": KIND_RPAREN,
      "{": KIND_LBRACE, "}": KIND_RBRACE, ";": KIND_SEMI, ",": KIND_COMMA
   };
   detail_type keywords[string] = '{
      "void": KW_VOID, "int": KW_INT, "char": KW_CHAR, "return": KW_RETURN
   };

   string kw_like[$] = '{
      "void", "int", "char", "return", "void", "int", "char", "return",
      "voi", "in", "cha", "retur", "voidx", "int_", "chars", "return9", "Void", "RETURN"
   };
   string ident_chars   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   string op_chars      = "+-*/%=!<>&|.";
   string punct_chars   = ":(){};,.";
   string ws_chars      = " \t\n";
   string directed_text = "void 9a 1_'x\n\"<<=.+'z";

   // scanner model state
   scan_mode_type   scan_mode;
   logic [7:0]      op_char;
   string           kw_text;
   logic [OB-1:0]   tok_off;
   logic [OB-1:0]   pos_off;
   logic [LCB-1:0]  tok_line;
   logic [LCB-1:0]  tok_col;
   logic [LCB-1:0]  pos_line;
   logic [LCB-1:0]  pos_col;
   logic [LB-1:0]   run_len;

   token_type       byte_tokens[$];
   token_type       pending_tokens[$];
   logic [7:0]      stim_bytes[$];
   stim_row_type    directed_rows[$];
   int              errors;
   bit              no_idle;

   function automatic longint unsigned saturate_inc(longint unsigned v, int bits);
      longint unsigned top;
      top = (64'd1 << bits) - 1;
      return (v >= top) ? v : v + 1;
   endfunction

   function automatic bit alpha(logic [7:0] c);
      return (c | 8'h20) >= "a" && (c | 8'h20) <= "z";
   endfunction

   function automatic bit numeral(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic void clear_scanner();
      scan_mode = SCAN_IDLE;
      op_char   = '0;
      kw_text   = "";
      tok_off   = '0;
      tok_line  = LCB'(1);
      tok_col   = LCB'(1);
      pos_off   = '0;
      pos_line  = LCB'(1);
      pos_col   = LCB'(1);
      run_len   = '0;
   endfunction

   function automatic void step_position(logic [7:0] c);
      pos_off = pos_off + 1'b1;
      if (c == "\n") begin
         pos_line = LCB'(saturate_inc(pos_line, LCB));
         pos_col  = LCB'(1);
      end else begin
         pos_col = LCB'(saturate_inc(pos_col, LCB));
      end
   endfunction

   function automatic void open_token();
      tok_off  = pos_off;
      tok_line = pos_line;
      tok_col  = pos_col;
   endfunction

   function automatic void emit(kind_type kind, detail_type detail, logic [OB-1:0] offset,
                                logic [LB-1:0] length, logic [LCB-1:0] line,
                                logic [LCB-1:0] column);
      token_type t;
      t.kind   = kind;
      t.detail = detail;
      t.offset = offset;
      t.length = length;
      t.line   = line;
      t.column = column;
      t.last   = 1'b0;
      byte_tokens.push_back(t);
   endfunction

   function automatic void emit_open(kind_type kind, detail_type detail, logic [LB-1:0] length);
      emit(kind, detail, tok_off, length, tok_line, tok_col);
   endfunction

   // byte seen with no token in progress
   function automatic void scan_between(logic [7:0] c);
      string ch;
      ch = $sformatf("%c", c);
      if (c == 8'd0) begin
         emit(KIND_END, DETAIL_NONE, pos_off, '0, pos_line, pos_col);
         clear_scanner();
         return;
      end
      if (c == " " || c == "\t" || c == "\n") begin
         step_position(c);
         return;
      end
      if (alpha(c) || c == "_") begin
         open_token();
         kw_text   = ch;
         run_len   = LB'(1);
         scan_mode = SCAN_IDENT;
      end else if (numeral(c)) begin
         open_token();
         run_len   = LB'(1);
         scan_mode = SCAN_NUMBER;
      end else if (c == "\"" || c == "'") begin
         open_token();
         tok_off   = pos_off + 1'b1;
         run_len   = '0;
         scan_mode = SCAN_STRING;
      end else if (op_singles.exists(ch)) begin
         open_token();
         op_char   = c;
         scan_mode = SCAN_OPER;
      end else if (punct_kinds.exists(ch)) begin
         emit(punct_kinds[ch], c == "." ? OP_DOT : DETAIL_NONE, pos_off, LB'(1), pos_line,
              pos_col);
      end else begin
         emit(KIND_ERROR, DETAIL_NONE, pos_off, LB'(1), pos_line, pos_col);
      end
      step_position(c);
   endfunction

   function automatic void predict_tokens(logic [7:0] c);
      bit        rescan;
      string     pair;
      token_type t;
      byte_tokens.delete();
      rescan = 1'b1;
      case (scan_mode)
         SCAN_IDENT: begin
            if (alpha(c) || numeral(c) || c == "_") begin
               if (run_len < KW_DEPTH) kw_text = {kw_text, $sformatf("%c", c)};
               run_len = LB'(saturate_inc(run_len, LB));
               step_position(c);
               rescan = 1'b0;
            end else if (run_len == kw_text.len() && keywords.exists(kw_text)) begin
               emit_open(KIND_KEYWORD, keywords[kw_text], run_len);
            end else begin
               emit_open(KIND_IDENT, DETAIL_NONE, run_len);
            end
         end
         SCAN_NUMBER: begin
            if (numeral(c)) begin
               run_len = LB'(saturate_inc(run_len, LB));
               step_position(c);
               rescan = 1'b0;
            end else begin
               emit_open(alpha(c) ? KIND_ERROR : KIND_NUMBER, DETAIL_NONE, run_len);
            end
         end
         SCAN_STRING: begin
            if (c == "\"") begin
               emit_open(KIND_STRING, DETAIL_NONE, run_len);
               scan_mode = SCAN_IDLE;
               step_position(c);
               rescan = 1'b0;
            end else if (c != 8'd0) begin
               run_len = LB'(saturate_inc(run_len, LB));
               step_position(c);
               rescan = 1'b0;
            end else begin
               emit_open(KIND_STRING, DETAIL_NONE, run_len);
            end
         end
         SCAN_OPER: begin
            pair = $sformatf("%c%c", op_char, c);
            if (c != 8'd0 && op_pairs.exists(pair)) begin
               emit_open(KIND_OPER, op_pairs[pair], LB'(2));
               scan_mode = SCAN_IDLE;
               step_position(c);
               rescan = 1'b0;
            end else begin
               emit_open(KIND_OPER, op_singles[$sformatf("%c", op_char)], LB'(1));
            end
         end
         default: ;
      endcase
      if (rescan) begin
         scan_mode = SCAN_IDLE;
         scan_between(c);
      end
      if (byte_tokens.size() > 0) begin
         t = byte_tokens.pop_back();
         t.last = 1'b1;
         byte_tokens.push_back(t);
      end
   endfunction

   task automatic report_mismatch(string what, longint unsigned want, longint unsigned seen);
      $display("MISMATCH %s: expected %0d, got %0d", what, want, seen);
      errors++;
   endtask

   task automatic check_token();
      token_type want;
      if (pending_tokens.size() == 0) begin
         report_mismatch("token word with nothing pending, kind", 0, rsp_tuser);
         return;
      end
      want = pending_tokens.pop_front();
      if (rsp_tuser !== want.kind)
         report_mismatch("kind", want.kind, rsp_tuser);
      if (rsp_tdata[DETAIL_W-1:0] !== want.detail)
         report_mismatch("detail", want.detail, rsp_tdata[DETAIL_W-1:0]);
      if (rsp_tdata[OFF_LSB +: OB] !== want.offset)
         report_mismatch("offset", want.offset, rsp_tdata[OFF_LSB +: OB]);
      if (rsp_tdata[LEN_LSB +: LB] !== want.length)
         report_mismatch("length", want.length, rsp_tdata[LEN_LSB +: LB]);
      if (rsp_tdata[LINE_LSB +: LCB] !== want.line)
         report_mismatch("line", want.line, rsp_tdata[LINE_LSB +: LCB]);
      if (rsp_tdata[COL_LSB +: LCB] !== want.column)
         report_mismatch("column", want.column, rsp_tdata[COL_LSB +: LCB]);
      if (rsp_tlast !== want.last)
         report_mismatch("tlast", want.last, rsp_tlast);
   endtask

   function automatic void append_text(string s);
      for (int i = 0; i < s.len(); i++) stim_bytes.push_back(s[i]);
   endfunction

   // one source: mostly well-formed tokens, some noise, closed by byte zero
   function automatic void build_source();
      int         target;
      int         r;
      logic [7:0] c;
      target = stim_bytes.size() + $urandom_range(4, 60);
      while (stim_bytes.size() < target) begin
         r = $urandom_range(0, 99);
         if (r < 20) begin
            if ($urandom_range(0, 2) == 0) begin
               append_text(kw_like[$urandom_range(0, kw_like.size() - 1)]);
            end else begin
               stim_bytes.push_back(ident_chars[$urandom_range(0, 52)]);
               repeat ($urandom_range(0, 8))
                  stim_bytes.push_back(ident_chars[$urandom_range(0, ident_chars.len() - 1)]);
            end
         end else if (r < 35) begin
            repeat ($urandom_range(1, 6)) stim_bytes.push_back(8'($urandom_range(48, 57)));
            case ($urandom_range(0, 9))
               0, 1, 2: stim_bytes.push_back(ident_chars[$urandom_range(0, 51)]);
               3:       stim_bytes.push_back("_");
               default: ;
            endcase
         end else if (r < 45) begin
            stim_bytes.push_back($urandom_range(0, 3) == 0 ? "'" : "\"");
            repeat ($urandom_range(0, 8)) begin
               case ($urandom_range(0, 9))
                  0:       c = "\n";
                  1:       c = "'";
                  2:       c = 8'($urandom_range(128, 255));
                  default: begin
                     c = 8'($urandom_range(32, 126));
                     if (c == "\"") c = "a";
                  end
               endcase
               stim_bytes.push_back(c);
            end
            if ($urandom_range(0, 6) != 0) stim_bytes.push_back("\"");
         end else if (r < 65) begin
            c = op_chars[$urandom_range(0, op_chars.len() - 1)];
            stim_bytes.push_back(c);
            case ($urandom_range(0, 3))
               0:       stim_bytes.push_back("=");
               1:       stim_bytes.push_back(c);
               2:       stim_bytes.push_back(op_chars[$urandom_range(0, op_chars.len() - 1)]);
               default: ;
            endcase
         end else if (r < 80) begin
            stim_bytes.push_back(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
         end else if (r < 90) begin
            stim_bytes.push_back(ws_chars[$urandom_range(0, ws_chars.len() - 1)]);
         end else begin
            stim_bytes.push_back(8'($urandom_range(1, 255)));
         end
         if ($urandom_range(0, 1) == 0) stim_bytes.push_back(" ");
      end
      // sometimes leave an operator waiting on the end byte
      if ($urandom_range(0, 7) == 0)
         stim_bytes.push_back(op_chars[$urandom_range(0, op_chars.len() - 2)]);
      stim_bytes.push_back(8'd0);
   endfunction

   task automatic send_byte(stim_row_type row);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= row.c;
      do @(posedge clock); while (!req_tready);
      predict_tokens(row.c);
      if (row.typed) pending_tokens.push_back(row.tok);
      else foreach (byte_tokens[i]) pending_tokens.push_back(byte_tokens[i]);
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_tokens.size() != 0);
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_600_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int gap;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
         repeat (gap) begin
            rsp_tready <= 1'b0;
            @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         check_token();
      end
   end

   initial begin
      int           half;
      stim_row_type row;
      errors     = 0;
      no_idle    = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      clear_scanner();

      // end byte right after reset, highest byte, carriage return
      row.typed = 1'b1;
      row.c = 8'd0;
      row.tok = '{KIND_END, DETAIL_NONE, 0, 0, 1, 1, 1'b1};
      directed_rows.push_back(row);
      row.c = 8'hFF;
      row.tok = '{KIND_ERROR, DETAIL_NONE, 0, 1, 1, 1, 1'b1};
      directed_rows.push_back(row);
      row.c = 8'h0D;
      row.tok = '{KIND_ERROR, DETAIL_NONE, 1, 1, 1, 2, 1'b1};
      directed_rows.push_back(row);
      row.typed = 1'b0;
      for (int i = 0; i < directed_text.len(); i++) begin
         row.c = directed_text[i];
         directed_rows.push_back(row);
      end
      row.c = 8'd0;
      directed_rows.push_back(row);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_byte(directed_rows[i]);
      hold_until_drained();

      while (stim_bytes.size() < RANDOM_BYTES) build_source();
      half = stim_bytes.size() / 2;
      foreach (stim_bytes[i]) begin
         if (i == half) hold_until_drained();
         if (stim_bytes[i] == 8'd0 && $urandom_range(0, 4) == 0) no_idle = ~no_idle;
         row.c = stim_bytes[i];
         send_byte(row);
      end

      // long identifier and a run of newlines at full rate
      no_idle = 1'b1;
      stim_bytes.delete();
      stim_bytes.push_back(8'd0);
      repeat (LONG_RUN) stim_bytes.push_back("q");
      stim_bytes.push_back(" ");
      repeat (LONG_RUN) stim_bytes.push_back("\n");
      append_text("x;");
      stim_bytes.push_back(8'd0);
      foreach (stim_bytes[i]) begin
         row.c = stim_bytes[i];
         send_byte(row);
      end

      hold_until_drained();
      repeat (16) @(posedge clock);
      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

[files.f]
sv/cstk_pkg.sv
sv/cstk_scan.sv
sv/cstk_outq.sv
sv/c_subset_token_scanner_core.sv
sv/cstk_checker.sv
dv/c_subset_token_scanner_core_test.sv
